>>> rtl/core/rgba_bm_pkg.sv
// ----------------------------------------------------------------------------
// RGBA blend mode unit package
// Shared constants and the blend mode code type.
// ----------------------------------------------------------------------------
package rgba_bm_pkg;

    // default channel width, 2^CHANNEL_BITS - 1 stands for 1.0
    localparam int CHANNEL_BITS_DEF = 8;

    // red, green, blue, alpha
    localparam int NUM_LANES  = 4;
    localparam int ALPHA_LANE = 3;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_SCREEN = 2'd1,
        MODE_DIFF   = 2'd2,
        MODE_DODGE  = 2'd3
    } t_blend_mode;

endpackage

>>> rtl/core/rgba_blend_mode_unit_top.sv
// ----------------------------------------------------------------------------
// RGBA blend mode unit
// Blends an existing RGBA pixel with a new RGBA colour under one of four
// modes (add, screen, difference, colour dodge), one pixel per clock.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                         | payload
//  ---------+-----+-----------------------------------+---------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | dst r,g,b,a then src r,g,b,a
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | out r,g,b,a
//  cfg      | in  | i_cfg_valid / o_cfg_ready         | blend_mode (2 bits)
//
//  One transaction per clock sustained while the output is not stalled. A pixel
//  passes the input register, stage 2, stage 3, the colour dodge divider, which
//  resolves one quotient bit per pipeline stage, and the output register.
//  Reset (synchronous, active low) clears all valid bits and sets the mode
//  to add. An output register plus one skid entry absorb a stall; o_s_axis_tready
//  is registered and drops only once the skid entry fills, freezing the whole
//  pipeline until the output drains. o_cfg_ready is always high; the user must
//  write the mode only while the unit is idle, which the unit does not enforce.
//
module rgba_blend_mode_unit_top #(
    parameter int CHANNEL_BITS = rgba_bm_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // slave stream
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // dst_red, dst_green, dst_blue, dst_alpha, src_red, src_green, src_blue,
    // src_alpha, CHANNEL_BITS each from bit 0 up, zero pad to whole bytes
    input  logic [((2*rgba_bm_pkg::NUM_LANES*CHANNEL_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // master stream
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha, CHANNEL_BITS each from bit 0 up,
    // zero pad to whole bytes
    output logic [((rgba_bm_pkg::NUM_LANES*CHANNEL_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // configuration
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [1:0]                              i_cfg_data
);

    localparam int N     = CHANNEL_BITS;
    localparam int W2    = 2 * N;
    localparam int LANES = rgba_bm_pkg::NUM_LANES;
    localparam int OUT_W = ((LANES * N + 7) / 8) * 8;

    localparam logic [N-1:0]  FULL   = {N{1'b1}};
    localparam logic [W2-1:0] HALF   = {{(N+1){1'b0}}, {(N-1){1'b1}}};
    localparam logic [W2:0]   FULL_X = {{(N+1){1'b0}}, {N{1'b1}}};

    // ------------------------------------------------------------------
    // mode register
    // ------------------------------------------------------------------
    rgba_bm_pkg::t_blend_mode r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rgba_bm_pkg::MODE_ADD;
        end else if (i_cfg_valid) begin
            r_mode <= rgba_bm_pkg::t_blend_mode'(i_cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // pipeline advance: all stages move together while the skid is empty
    // ------------------------------------------------------------------
    logic r_skid_v;
    logic w_adv;

    assign w_adv           = !r_skid_v;
    assign o_s_axis_tready = w_adv;

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic                     r1_v;
    rgba_bm_pkg::t_blend_mode r1_mode;
    logic [N-1:0]             r1_a [LANES];
    logic [N-1:0]             r1_b [LANES];

    // ------------------------------------------------------------------
    // stage 2: simple modes, screen product, dodge numerator/denominator
    // ------------------------------------------------------------------
    logic                     r2_v;
    rgba_bm_pkg::t_blend_mode r2_mode;
    logic [N-1:0]             r2_res  [LANES];
    logic [W2-1:0]            r2_prod [LANES];
    logic [W2-1:0]            r2_num  [LANES];
    logic [N-1:0]             r2_den  [LANES];

    logic [N-1:0]             n2_res  [LANES];
    logic [W2-1:0]            n2_prod [LANES];
    logic [W2-1:0]            n2_num  [LANES];
    logic [N-1:0]             n2_den  [LANES];

    always_comb begin
        logic [N:0]   sum;
        logic [N-1:0] ia;
        logic [N-1:0] ib;
        logic [N-1:0] mx;
        logic [N-1:0] df;
        for (int l = 0; l < LANES; l++) begin
            sum = {1'b0, r1_a[l]} + {1'b0, r1_b[l]};
            ia  = FULL - r1_a[l];
            ib  = FULL - r1_b[l];
            mx  = (r1_a[l] > r1_b[l]) ? r1_a[l] : r1_b[l];
            df  = (r1_a[l] > r1_b[l]) ? (r1_a[l] - r1_b[l]) : (r1_b[l] - r1_a[l]);
            unique case (r1_mode)
                rgba_bm_pkg::MODE_ADD: begin
                    n2_res[l] = sum[N] ? FULL : sum[N-1:0];
                end
                rgba_bm_pkg::MODE_SCREEN: begin
                    n2_res[l] = '0;    // filled in after the divide by FULL
                end
                rgba_bm_pkg::MODE_DIFF: begin
                    n2_res[l] = (l == rgba_bm_pkg::ALPHA_LANE) ? mx : df;
                end
                rgba_bm_pkg::MODE_DODGE: begin
                    n2_res[l] = mx;    // alpha only; colour lanes take the quotient
                end
                default: begin
                    n2_res[l] = '0;
                end
            endcase
            n2_prod[l] = W2'(ia) * W2'(ib);
            // a * FULL = (a << N) - a
            n2_num[l]  = {r1_a[l], {N{1'b0}}} - {{N{1'b0}}, r1_a[l]};
            n2_den[l]  = ib;
        end
    end

    // ------------------------------------------------------------------
    // divider chain, index 0 is stage 3, index k+1 resolves bit N-1-k
    // ------------------------------------------------------------------
    logic                     r_dv_v    [N+1];
    rgba_bm_pkg::t_blend_mode r_dv_mode [N+1];
    logic [N-1:0]             r_dv_res  [N+1][LANES];
    logic [W2-1:0]            r_dv_rem  [N+1][LANES];
    logic [N-1:0]             r_dv_den  [N+1][LANES];
    logic [N-1:0]             r_dv_quo  [N+1][LANES];
    logic                     r_dv_sat  [N+1][LANES];

    // stage 3 screen terms
    logic [W2-1:0]            r3_x  [LANES];
    logic [N-1:0]             r3_q0 [LANES];

    logic [W2-1:0]            n3_x   [LANES];
    logic [N-1:0]             n3_q0  [LANES];
    logic                     n3_sat [LANES];

    // x / FULL estimate: (x + (x >> N)) >> N, low by at most one
    always_comb begin
        logic [W2:0] s;
        for (int l = 0; l < LANES; l++) begin
            n3_x[l]   = r2_prod[l] + HALF;
            s         = {1'b0, n3_x[l]} + {{(N+1){1'b0}}, n3_x[l][W2-1:N]};
            n3_q0[l]  = s[W2-1:N];
            // quotient would need N+1 bits (covers a zero divisor too)
            n3_sat[l] = (r2_num[l] >= {r2_den[l], {N{1'b0}}});
        end
    end

    // screen correction, evaluated on stage 3 registers
    logic [N-1:0] n_scr [LANES];

    always_comb begin
        logic [W2:0] rm;
        logic        inc;
        for (int l = 0; l < LANES; l++) begin
            rm  = {1'b0, r3_x[l]} + {{(N+1){1'b0}}, r3_q0[l]}
                - {1'b0, r3_q0[l], {N{1'b0}}};
            inc = (rm >= FULL_X);
            n_scr[l] = FULL - r3_q0[l] - {{(N-1){1'b0}}, inc};
        end
    end

    // ------------------------------------------------------------------
    // stage registers 1..3, valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r1_v      <= i_s_axis_tvalid;
            r2_v      <= r1_v;
            r_dv_v[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mode      <= r_mode;
            r2_mode      <= r1_mode;
            r_dv_mode[0] <= r2_mode;
            for (int l = 0; l < LANES; l++) begin
                r1_a[l]        <= i_s_axis_tdata[l*N +: N];
                r1_b[l]        <= i_s_axis_tdata[(LANES+l)*N +: N];
                r2_res[l]      <= n2_res[l];
                r2_prod[l]     <= n2_prod[l];
                r2_num[l]      <= n2_num[l];
                r2_den[l]      <= n2_den[l];
                r_dv_res[0][l] <= r2_res[l];
                r_dv_rem[0][l] <= r2_num[l];
                r_dv_den[0][l] <= r2_den[l];
                r_dv_quo[0][l] <= '0;
                r_dv_sat[0][l] <= n3_sat[l];
                r3_x[l]        <= n3_x[l];
                r3_q0[l]       <= n3_q0[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // restoring divide, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [N-1:0]  n_res [LANES];
        logic [W2-1:0] n_rem [LANES];
        logic [N-1:0]  n_quo [LANES];

        always_comb begin
            logic [W2-1:0] dsh;
            logic          ge;
            for (int l = 0; l < LANES; l++) begin
                dsh = {{N{1'b0}}, r_dv_den[k][l]} << (N - 1 - k);
                ge  = (r_dv_rem[k][l] >= dsh);
                n_rem[l] = ge ? (r_dv_rem[k][l] - dsh) : r_dv_rem[k][l];
                n_quo[l] = r_dv_quo[k][l];
                n_quo[l][N-1-k] = ge;
                if (k == 0 && r_dv_mode[k] == rgba_bm_pkg::MODE_SCREEN) begin
                    n_res[l] = n_scr[l];
                end else begin
                    n_res[l] = r_dv_res[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_mode[k+1] <= r_dv_mode[k];
                for (int l = 0; l < LANES; l++) begin
                    r_dv_res[k+1][l] <= n_res[l];
                    r_dv_rem[k+1][l] <= n_rem[l];
                    r_dv_den[k+1][l] <= r_dv_den[k][l];
                    r_dv_quo[k+1][l] <= n_quo[l];
                    r_dv_sat[k+1][l] <= r_dv_sat[k][l];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // final select and pack
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] n_pix;

    always_comb begin
        n_pix = '0;
        for (int l = 0; l < LANES; l++) begin
            if (r_dv_mode[N] == rgba_bm_pkg::MODE_DODGE && l != rgba_bm_pkg::ALPHA_LANE) begin
                n_pix[l*N +: N] = r_dv_sat[N][l] ? FULL : r_dv_quo[N][l];
            end else begin
                n_pix[l*N +: N] = r_dv_res[N][l];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register and skid entry
    // ------------------------------------------------------------------
    logic             r_out_v;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] r_skid_data;

    logic             n_out_v;
    logic             n_skid_v;
    logic             n_out_load;
    logic             n_out_from_skid;
    logic             n_skid_load;

    always_comb begin
        n_out_v         = r_out_v;
        n_skid_v        = r_skid_v;
        n_out_load      = 1'b0;
        n_out_from_skid = 1'b0;
        n_skid_load     = 1'b0;
        if (r_skid_v) begin
            // pipeline frozen, drain skid into the output register
            if (i_m_axis_tready) begin
                n_out_from_skid = 1'b1;
                n_skid_v        = 1'b0;
            end
        end else if (r_dv_v[N]) begin
            if (!r_out_v || i_m_axis_tready) begin
                n_out_load = 1'b1;
                n_out_v    = 1'b1;
            end else begin
                n_skid_load = 1'b1;
                n_skid_v    = 1'b1;
            end
        end else if (i_m_axis_tready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_load) begin
            r_out_data <= n_pix;
        end else if (n_out_from_skid) begin
            r_out_data <= r_skid_data;
        end
        if (n_skid_load) begin
            r_skid_data <= n_pix;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> tb/sv/rgba_blend_mode_unit_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA blend mode unit testbench
// Streams pixel pairs through the unit in every blend mode, predicts each
// blended pixel on the input handshake and checks every output channel in
// order. Both stream sides idle at random, and one long output stall backs
// up the pipeline.
// ----------------------------------------------------------------------------
module rgba_blend_mode_unit_top_test;

    localparam int CW          = rgba_bm_pkg::CHANNEL_BITS_DEF;
    localparam int NUM_LANES   = rgba_bm_pkg::NUM_LANES;
    localparam int ALPHA_LANE  = rgba_bm_pkg::ALPHA_LANE;
    localparam int FULL        = (1 << CW) - 1;
    localparam int IN_W        = ((2 * NUM_LANES * CW + 7) / 8) * 8;
    localparam int OUT_W       = ((NUM_LANES * CW + 7) / 8) * 8;
    // input acceptance to output valid
    localparam int LATENCY     = CW + 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;     // blended pixels seen before the stall
    localparam int PHASE_ITEMS = 230;
    localparam int RAND_PHASES = 8;
    localparam int IDLE_PCT    = 31;
    localparam int CALM_START  = 2000;    // window with no idling on either side
    localparam int CALM_END    = 3000;
    localparam int MAX_PRINTS  = 40;

    typedef logic [CW-1:0] t_chan;

    // red in the low bits, as on the stream
    typedef struct packed {
        t_chan alpha;
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_rgba;

    localparam string LANE_NAMES [NUM_LANES] = '{"red", "green", "blue", "alpha"};

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata  = '0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;
    logic             i_cfg_valid     = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_data      = '0;

    rgba_blend_mode_unit_top #(
        .CHANNEL_BITS (CW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // pixel pairs waiting for the driver, blends waiting for the output
    logic [IN_W-1:0] pending_pixels [$];
    t_rgba           expected_blends [$];

    rgba_bm_pkg::t_blend_mode mode_model = rgba_bm_pkg::MODE_ADD; // mirror of the mode register
    int          errors     = 0;
    int          cyc        = 0;
    int          pixels_in  = 0;
    int          blends_out = 0;
    int          hold_left  = 0;
    logic        hold_done  = 1'b0;
    int          phases_run = 0;
    logic        idle_ok;

    assign idle_ok = !(cyc >= CALM_START && cyc < CALM_END);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    // a is the existing pixel channel, b the new colour channel
    function automatic t_chan blend_lane(rgba_bm_pkg::t_blend_mode mode, int lane,
                                         t_chan a, t_chan b);
        int ia;
        int ib;
        int r;
        ia = a;
        ib = b;
        case (mode)
            rgba_bm_pkg::MODE_ADD: begin
                r = (ia + ib > FULL) ? FULL : ia + ib;
            end
            rgba_bm_pkg::MODE_SCREEN: begin
                // FULL is odd, so adding half of it never lands on a tie
                r = FULL - (((FULL - ia) * (FULL - ib) + FULL / 2) / FULL);
            end
            rgba_bm_pkg::MODE_DIFF: begin
                if (lane == ALPHA_LANE)
                    r = (ia > ib) ? ia : ib;
                else
                    r = (ia > ib) ? ia - ib : ib - ia;
            end
            default: begin
                if (lane == ALPHA_LANE) begin
                    r = (ia > ib) ? ia : ib;
                end else if (ib == FULL) begin
                    r = FULL;     // dodge with a full new colour saturates
                end else begin
                    r = (ia * FULL) / (FULL - ib);
                    if (r > FULL)
                        r = FULL;
                end
            end
        endcase
        return t_chan'(r);
    endfunction

    function automatic t_rgba blend_pixel(rgba_bm_pkg::t_blend_mode mode,
                                          logic [IN_W-1:0] data);
        logic [NUM_LANES*CW-1:0] flat;
        flat = '0;
        for (int lane = 0; lane < NUM_LANES; lane++) begin
            flat[lane*CW +: CW] = blend_lane(mode, lane, data[lane*CW +: CW],
                                             data[(NUM_LANES+lane)*CW +: CW]);
        end
        return t_rgba'(flat);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_rgba rgba(int r, int g, int b, int a);
        t_rgba p;
        p.red   = t_chan'(r);
        p.green = t_chan'(g);
        p.blue  = t_chan'(b);
        p.alpha = t_chan'(a);
        return p;
    endfunction

    function automatic logic [IN_W-1:0] pixel_pair(t_rgba dst, t_rgba src);
        logic [IN_W-1:0] d;
        d = '0;
        d[NUM_LANES*CW-1:0]             = dst;
        d[2*NUM_LANES*CW-1:NUM_LANES*CW] = src;
        return d;
    endfunction

    // a quarter of the channels hit the edges, where saturation and the
    // dodge divide by a small denominator live
    function automatic t_chan rand_chan();
        t_chan c;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0:       c = '0;
                1:       c = t_chan'(1);
                2:       c = t_chan'(FULL - 1);
                3:       c = t_chan'(FULL / 2);
                4:       c = t_chan'(FULL / 2 + 1);
                default: c = t_chan'(FULL);
            endcase
        end else begin
            c = t_chan'($urandom_range(0, FULL));
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("[%0d] MISMATCH %s: got %0d expected %0d (mode %s)",
                     cyc, what, got, want, mode_model.name());
    endtask

    // edges of every channel: zero, full, opposite extremes, near-full new
    // colour for dodge, equal channels for difference
    task automatic queue_directed();
        @(negedge i_clk);
        pending_pixels.push_back(pixel_pair(rgba(0, 0, 0, 0), rgba(0, 0, 0, 0)));
        pending_pixels.push_back(pixel_pair(rgba(FULL, FULL, FULL, FULL),
                                            rgba(FULL, FULL, FULL, FULL)));
        pending_pixels.push_back(pixel_pair(rgba(0, FULL, 0, FULL),
                                            rgba(FULL, 0, FULL, 0)));
        pending_pixels.push_back(pixel_pair(rgba(1, FULL - 1, 128, 127),
                                            rgba(FULL - 1, 1, 127, 128)));
        pending_pixels.push_back(pixel_pair(rgba(200, 100, FULL, 0),
                                            rgba(FULL - 1, FULL - 2, FULL, FULL)));
        pending_pixels.push_back(pixel_pair(rgba(100, 50, 3, 77),
                                            rgba(100, 200, 250, 77)));
    endtask

    task automatic queue_random(int count);
        @(negedge i_clk);
        repeat (count) begin
            pending_pixels.push_back(pixel_pair(
                rgba(rand_chan(), rand_chan(), rand_chan(), rand_chan()),
                rgba(rand_chan(), rand_chan(), rand_chan(), rand_chan())));
        end
    endtask

    // wait until everything sent has come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_s_axis_tvalid || expected_blends.size() != 0);
        phases_run++;
    endtask

    // mode is only written while idle: let the pipeline settle first
    task automatic set_mode(rgba_bm_pkg::t_blend_mode mode);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: holds a transaction until taken, idles at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_pixels.size() != 0 &&
                !(idle_ok && $urandom_range(0, 99) < IDLE_PCT)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= pending_pixels.pop_front();
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output sink: random backpressure plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (hold_left == 0) &&
                               !(idle_ok && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // long stall counted here; the driver keeps offering so the unit fills
    // its skid entry and drops o_s_axis_tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && blends_out >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input transaction, check on output transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rgba want;
        t_rgba got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_blends.push_back(blend_pixel(mode_model, i_s_axis_tdata));
                pixels_in <= pixels_in + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                blends_out <= blends_out + 1;
                got = t_rgba'(o_m_axis_tdata[NUM_LANES*CW-1:0]);
                if (expected_blends.size() == 0) begin
                    report_mismatch("output with nothing pending, data", got, 0);
                end else begin
                    want = expected_blends.pop_front();
                    for (int lane = 0; lane < NUM_LANES; lane++) begin
                        if (got[lane*CW +: CW] !== want[lane*CW +: CW])
                            report_mismatch(LANE_NAMES[lane], got[lane*CW +: CW],
                                            want[lane*CW +: CW]);
                    end
                end
            end
            // mode writes happen only while idle, so no pixel sees the change early
            if (i_cfg_valid && o_cfg_ready)
                mode_model = rgba_bm_pkg::t_blend_mode'(i_cfg_data);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        rgba_bm_pkg::t_blend_mode modes [RAND_PHASES];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed set in every mode, the first one in the reset mode
        for (int m = 0; m < NUM_LANES; m++) begin
            if (m != 0)
                set_mode(rgba_bm_pkg::t_blend_mode'(m));
            queue_directed();
            drain();
        end

        // random phases: every mode once, then random picks
        modes[0] = rgba_bm_pkg::MODE_DODGE;
        modes[1] = rgba_bm_pkg::MODE_ADD;
        modes[2] = rgba_bm_pkg::MODE_SCREEN;
        modes[3] = rgba_bm_pkg::MODE_DIFF;
        for (int p = 4; p < RAND_PHASES; p++)
            modes[p] = rgba_bm_pkg::t_blend_mode'($urandom_range(0, 3));
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_mode(modes[p]);
            queue_random(PHASE_ITEMS);
            drain();
        end

        // catch stray outputs after the last expected one
        repeat (4 * LATENCY) @(posedge i_clk);

        $display("Blended %0d pixels (%0d checked) over %0d mode phases, all four modes,",
                 pixels_in, blends_out, phases_run);
        $display("with random idling on both sides and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
